// ----- sv/ppq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_pkg
// types and constants shared by the paced packet queue
// ----------------------------------------------------------------------------
package ppq_pkg;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_MARK = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_NOTFD = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [21:0] BYTES_MAX     = 22'h3FFFFF;
  localparam logic [15:0] RETIRED_SPACE = 16'd500;
  localparam logic [15:0] CFG_RESET     = 16'd2000;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_APPLY, S_RETIRE, S_RETIRE_RD, S_FRONT, S_DIV, S_OUT
  } state_t;

endpackage

// ----- sv/ppq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module ppq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/ppq_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppq_div
// restoring divider, one quotient bit per cycle, 25 bit by 16 bit
// ----------------------------------------------------------------------------
module ppq_div
  import ppq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [24:0] dividend,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [24:0] quotient
);
  logic [4:0]  cnt;
  logic [24:0] quo;
  logic [16:0] rem;
  logic [16:0] trial;

  assign trial = {rem[15:0], quo[24]} - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd24;
      quo  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      if (!trial[16]) begin
        rem <= trial;
        quo <= {quo[23:0], 1'b1};
      end else begin
        rem <= {rem[15:0], quo[24]};
        quo <= {quo[23:0], 1'b0};
      end
      if (cnt == 5'd0) busy <= 1'b0;
      else cnt <= cnt - 5'd1;
    end
  end
endmodule

// ----- sv/pacing_packet_queue.sv -----
`timescale 1ns / 1ps
// a push or query searches the queue for the id, scans it for the front entry and then
//   runs the bit serial divider; a found mark also retires sent entries from the head
// throughput: one item at a time, stall held high while an item is at work
//   and while the result waits on out_stall
// reset: synchronous, clears the queue, the sent bits and the oldest time;
//   the budget returns to 2000 ms
// ----------------------------------------------------------------------------
// pacing_packet_queue
// paced packet queue with duplicate check, retirement and target bitrate
// ----------------------------------------------------------------------------
module pacing_packet_queue
  import ppq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] packet_id,
  input  logic [15:0] packet_bytes,
  input  logic [39:0] queue_time,
  input  logic [39:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        front_valid,
  output logic [31:0] front_id,
  output logic [21:0] queued_bytes,
  output logic [39:0] oldest_ms,
  output logic        queue_empty,
  output logic [24:0] bitrate_kbps
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int RW = 32 + 16 + 40;

  state_t state, state_next;
  logic [15:0] max_queue_ms;
  logic [DEPTH-1:0] sent;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [21:0] total;
  logic [39:0] oldest;
  logic oldest_ok;

  logic [1:0]  cmd_r;
  logic [31:0] id_r;
  logic [15:0] bytes_r;
  logic [39:0] qt_r, now_r;
  logic [CW-1:0] k;
  logic          rd_pend;
  logic          found;
  logic [AW-1:0] fslot;
  logic [15:0]   fbytes;
  logic          fv;
  logic [31:0]   fid;

  logic          we;
  logic [AW-1:0] waddr, raddr, kslot, rslot;
  logic [RW-1:0] rdata;
  logic [31:0]   r_id;
  logic [15:0]   r_bytes;
  logic [39:0]   r_time;
  logic [AW-1:0] pslot;

  logic        div_start, div_busy;
  logic [24:0] div_q;
  logic [15:0] budget, space;
  logic [39:0] diff;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [CW-1:0] o);
    logic [CW:0] s;
    s = {1'b0, {(CW-AW){1'b0}}, h} + {1'b0, o};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign kslot = wrap(head, k);
  assign pslot = wrap(head, count);
  assign {r_id, r_bytes, r_time} = rdata;
  assign we = (state == S_APPLY) && (cmd_r == CMD_PUSH) && !found
              && (count < CW'(DEPTH));
  assign waddr = pslot;
  assign raddr = (state == S_APPLY || state == S_RETIRE) ? rslot : kslot;

  ppq_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata({id_r, bytes_r, qt_r}),
    .raddr(raddr), .rdata(rdata)
  );

  assign budget = (max_queue_ms < 16'd2) ? 16'd2 : max_queue_ms;
  assign diff = now_r - oldest;
  always_comb begin
    if (oldest_ok && now_r > oldest) begin
      if (diff >= {24'd0, budget}) space = RETIRED_SPACE;
      else space = budget - diff[15:0];
    end else begin
      space = budget - 16'd1;
    end
  end

  ppq_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend({total, 3'b000}),
    .divisor(space), .busy(div_busy), .quotient(div_q)
  );

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    rslot = head;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_FIND;
      S_FIND:   if (rd_pend && r_id == id_r) state_next = S_APPLY;
                else if (!rd_pend && k >= count) state_next = S_APPLY;
      S_APPLY:  state_next = (cmd_r == CMD_MARK && found) ? S_RETIRE : S_FRONT;
      S_RETIRE: if (count == '0 || !sent[head]) state_next = S_RETIRE_RD;
      S_RETIRE_RD: state_next = S_FRONT;
      S_FRONT:  if (!rd_pend && k >= count) begin
                  state_next = S_DIV;
                  div_start = 1'b1;
                end
      S_DIV:    if (!div_busy && !div_start) state_next = S_OUT;
      S_OUT:    if (!out_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign out_valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_queue_ms <= CFG_RESET;
      sent <= '0;
      head <= '0;
      count <= '0;
      total <= '0;
      oldest <= '0;
      oldest_ok <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (cfg_we) max_queue_ms <= cfg_wdata;
      case (state)
        S_IDLE: if (in_valid) begin
          cmd_r <= command;
          id_r <= packet_id;
          bytes_r <= packet_bytes;
          qt_r <= queue_time;
          now_r <= now_ms;
          k <= '0;
          found <= 1'b0;
          rd_pend <= 1'b0;
        end
        S_FIND: begin
          if (rd_pend && r_id == id_r) begin
            found <= 1'b1;
            fbytes <= r_bytes;
            rd_pend <= 1'b0;
          end else if (k < count) begin
            fslot <= kslot;
            k <= k + CW'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        S_APPLY: begin
          if (cmd_r == CMD_PUSH) begin
            if (found) status <= ST_DUP;
            else if (count >= CW'(DEPTH)) status <= ST_FULL;
            else begin
              status <= ST_OK;
              sent[pslot] <= 1'b0;
              count <= count + CW'(1);
              if ({1'b0, total} + {7'd0, bytes_r} > {1'b0, BYTES_MAX}) total <= BYTES_MAX;
              else total <= total + {6'd0, bytes_r};
            end
            if (!oldest_ok || oldest > qt_r) begin
              oldest_ok <= 1'b1;
              oldest <= qt_r;
            end
          end else if (cmd_r == CMD_MARK) begin
            if (!found) status <= ST_NOTFD;
            else begin
              status <= ST_OK;
              sent[fslot] <= 1'b1;
              if (total >= {6'd0, fbytes}) total <= total - {6'd0, fbytes};
              else total <= '0;
            end
          end else begin
            status <= ST_OK;
          end
          k <= '0;
        end
        S_RETIRE: begin
          if (count != '0 && sent[head]) begin
            sent[head] <= 1'b0;
            head <= wrap(head, CW'(1));
            count <= count - CW'(1);
          end
        end
        S_RETIRE_RD: begin
          if (count == '0) begin
            total <= '0;
            oldest_ok <= 1'b0;
            oldest <= '0;
          end else begin
            oldest_ok <= 1'b1;
            oldest <= r_time;
          end
        end
        S_FRONT: begin
          if (rd_pend && !sent[fslot] && (!fv || r_id < fid)) begin
            fv <= 1'b1;
            fid <= r_id;
          end
          if (k < count) begin
            fslot <= kslot;
            k <= k + CW'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
          end
        end
        S_DIV: if (!div_busy && !div_start) begin
          front_valid <= fv;
          front_id <= fv ? fid : 32'd0;
          queued_bytes <= total;
          oldest_ms <= oldest_ok ? oldest : now_r;
          queue_empty <= (count == '0);
          bitrate_kbps <= (count != '0 && total != '0) ? div_q : 25'd0;
        end
        default: ;
      endcase
      if (state == S_APPLY) begin
        fv <= 1'b0;
        fid <= '0;
      end
    end
  end

`ifndef SYNTH
  a_count: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("count above depth");
  a_stall: assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input open while result pending");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_empty) |-> (queued_bytes == 22'd0 && !front_valid))
    else $error("empty queue reports content");
`endif
endmodule
